>>> hdl/lrupr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement - shared types and constants
// Payload structs for the reference and result channels, plus the command
// and status groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package lrupr_pkg;

    localparam int PAGE_W  = 16;
    localparam int SLOT_W  = 3;
    localparam int CFG_W   = 4;
    // wide enough to hold any frame limit up to 32
    localparam int LIMIT_W = 6;

    localparam logic [CFG_W-1:0]  CFG_RESET = 4'd8;
    localparam logic [PAGE_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              first;
    } t_ref;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted_valid;
        logic [PAGE_W-1:0] evicted_page;
        logic [PAGE_W-1:0] miss_total;
    } t_res;

    typedef struct packed {
        logic load;
        logic lookup;
        logic scan;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic fill;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

>>> hdl/lrupr_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement - valid/ready stream channel
// Carries one item of type T per handshake.
// ----------------------------------------------------------------------------
interface lrupr_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/lrupr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement - controller
// Sequences one reference at a time: load, lookup, optional victim scan,
// then state update into the result register.
// ----------------------------------------------------------------------------
module lrupr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output lrupr_pkg::t_cmd  o_cmd,
    input  lrupr_pkg::t_sts  i_sts
);
    import lrupr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_UPD
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.lookup = 1'b1;
                n_state      = (i_sts.hit || i_sts.fill) ? S_UPD : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                // hold until the result register can take the item
                if (i_sts.out_free) begin
                    o_cmd.update = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/lrupr_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement - datapath
// Frame tags, valid bits, recency ranks, miss counter, frame limit register
// and the result register. Acts on commands from the controller.
// ----------------------------------------------------------------------------
module lrupr_dpath #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lrupr_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  lrupr_pkg::t_ref               i_ref,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output lrupr_pkg::t_res               o_res,
    input  lrupr_pkg::t_cmd               i_cmd,
    output lrupr_pkg::t_sts               o_sts
);
    import lrupr_pkg::*;

    localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    logic [PAGE_BITS-1:0]  r_frame_page [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] r_valid;
    logic [IW-1:0]         r_rank [MAX_FRAMES];
    logic [PAGE_W-1:0]     r_miss_cnt;
    logic [CFG_W-1:0]      r_frames_in_use;
    logic [PAGE_BITS-1:0]  r_ref_page;
    logic                  r_hit;
    logic                  r_fill;
    logic [IW-1:0]         r_idx;
    logic [IW-1:0]         r_best_idx;
    logic [IW-1:0]         r_best_rank;
    t_res                  r_res;
    logic                  r_out_valid;

    logic [LIMIT_W-1:0]    w_cfg_ext;
    logic [LIMIT_W-1:0]    w_limit;
    logic                  w_match_found;
    logic [IW-1:0]         w_match_idx;
    logic                  w_free_found;
    logic [IW-1:0]         w_free_idx;
    logic [IW-1:0]         w_rd_rank;
    logic [PAGE_BITS-1:0]  w_rd_page;
    logic                  w_take;
    logic [IW-1:0]         w_cand_idx;
    logic                  w_scan_last;
    logic                  w_ev;
    logic [PAGE_W-1:0]     n_miss_cnt;
    logic [IW-1:0]         n_rank [MAX_FRAMES];

    // clamp the configured limit to 1..MAX_FRAMES
    always_comb begin
        w_cfg_ext = LIMIT_W'(r_frames_in_use);
        priority if (w_cfg_ext == '0) begin
            w_limit = LIMIT_W'(1);
        end else if (w_cfg_ext > LIMIT_W'(MAX_FRAMES)) begin
            w_limit = LIMIT_W'(MAX_FRAMES);
        end else begin
            w_limit = w_cfg_ext;
        end
    end

    // parallel tag compare and lowest empty frame below the limit
    always_comb begin
        w_match_found = 1'b0;
        w_match_idx   = '0;
        w_free_found  = 1'b0;
        w_free_idx    = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (!w_match_found && r_valid[i] && (r_frame_page[i] == r_ref_page)) begin
                w_match_found = 1'b1;
                w_match_idx   = IW'(i);
            end
            if (!w_free_found && !r_valid[i] && (LIMIT_W'(i) < w_limit)) begin
                w_free_found = 1'b1;
                w_free_idx   = IW'(i);
            end
        end
    end

    // indexed read of the frame arrays at r_idx
    assign w_rd_rank   = r_rank[r_idx];
    assign w_rd_page   = r_frame_page[r_idx];

    assign w_take      = w_rd_rank > r_best_rank;
    assign w_cand_idx  = w_take ? r_idx : r_best_idx;
    assign w_scan_last = LIMIT_W'(r_idx) == (w_limit - LIMIT_W'(1));

    assign w_ev        = !r_hit && !r_fill;
    assign n_miss_cnt  = (r_miss_cnt == COUNT_MAX) ? r_miss_cnt : r_miss_cnt + PAGE_W'(1);

    // age frames more recent than the touched one; a fill ages every valid frame
    always_comb begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            n_rank[i] = r_rank[i];
            if ((IW'(i) != r_idx) && r_valid[i] && (r_fill || (r_rank[i] < w_rd_rank))) begin
                n_rank[i] = r_rank[i] + IW'(1);
            end
        end
        n_rank[r_idx] = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid         <= '0;
            r_miss_cnt      <= '0;
            r_frames_in_use <= CFG_RESET;
            r_out_valid     <= 1'b0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_frames_in_use <= i_cfg_wdata;
            end
            if (r_out_valid && i_out_ready && !i_cmd.update) begin
                r_out_valid <= 1'b0;
            end
            // start marker drops all frames and the count before the lookup
            if (i_cmd.load && i_ref.first) begin
                r_valid    <= '0;
                r_miss_cnt <= '0;
                for (int i = 0; i < MAX_FRAMES; i++) begin
                    r_rank[i] <= '0;
                end
            end
            if (i_cmd.update) begin
                for (int i = 0; i < MAX_FRAMES; i++) begin
                    r_rank[i] <= n_rank[i];
                end
                if (!r_hit) begin
                    r_miss_cnt <= n_miss_cnt;
                end
                if (r_fill) begin
                    r_valid[r_idx] <= 1'b1;
                end
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ref_page <= PAGE_BITS'(i_ref.page);
        end
        if (i_cmd.lookup) begin
            r_hit       <= w_match_found;
            r_fill      <= !w_match_found && w_free_found;
            r_best_idx  <= '0;
            r_best_rank <= '0;
            if (w_match_found) begin
                r_idx <= w_match_idx;
            end else if (w_free_found) begin
                r_idx <= w_free_idx;
            end else begin
                r_idx <= '0;
            end
        end
        if (i_cmd.scan) begin
            r_best_idx <= w_cand_idx;
            if (w_take) begin
                r_best_rank <= w_rd_rank;
            end
            r_idx <= w_scan_last ? w_cand_idx : r_idx + IW'(1);
        end
        if (i_cmd.update) begin
            if (!r_hit) begin
                r_frame_page[r_idx] <= r_ref_page;
            end
            r_res.hit           <= r_hit;
            r_res.slot          <= SLOT_W'(r_idx);
            r_res.evicted_valid <= w_ev;
            r_res.evicted_page  <= w_ev ? PAGE_W'(w_rd_page) : '0;
            r_res.miss_total    <= r_hit ? r_miss_cnt : n_miss_cnt;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_res           = r_res;
    assign o_sts.hit       = w_match_found;
    assign o_sts.fill      = !w_match_found && w_free_found;
    assign o_sts.scan_last = w_scan_last;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // victim scan never leaves the frames the policy may use
    a_scan_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> (LIMIT_W'(r_idx) < w_limit))
        else $error("victim scan beyond frame limit");

    // touched frame becomes most recent
    a_touch_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |=> (r_rank[$past(r_idx)] == '0))
        else $error("touched frame not most recent");

    // a filled frame is valid afterwards
    a_fill_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && r_fill) |=> r_valid[$past(r_idx)])
        else $error("filled frame not marked valid");

    // a miss leaves a non-zero count
    a_miss_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && !r_hit) |=> (r_miss_cnt != '0))
        else $error("miss not counted");

endmodule

>>> hdl/lru_page_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement - top level
// Fully associative page frames with true LRU replacement and a saturating
// miss counter.
//
//   Port        Dir  Handshake     Payload
//   i_ref       in   valid/ready   page, first
//   o_res       out  valid/ready   hit, slot, evicted_valid, evicted_page,
//                                  miss_total
//   i_cfg_we    in   write enable  i_cfg_wdata = frames_in_use
//
// Hits and fills into an empty frame go through accept, tag compare and
// update; a replacement adds an oldest-frame scan over the frames in the
// limit, which reads one recency rank a cycle.
// Synchronous active-low reset empties all frames, clears the count and
// sets the frame limit to 8; no clearing pass is needed.
// The next item is accepted while a result waits in the output register;
// the update step stalls only while that register is still full.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lrupr_pkg::CFG_W-1:0] i_cfg_wdata,
    lrupr_stream_if.sink                i_ref,
    lrupr_stream_if.source              o_res
);
    import lrupr_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;
    logic w_out_valid;
    t_res w_res;

    lrupr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_ref.valid),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    lrupr_dpath #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_ref       (i_ref.data),
        .i_out_ready (o_res.ready),
        .o_out_valid (w_out_valid),
        .o_res       (w_res),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

    assign i_ref.ready = w_in_ready;
    assign o_res.valid = w_out_valid;
    assign o_res.data  = w_res;

endmodule
